/* hw/rtl/efe_pkg.sv */
// ----------------------------------------------------------------------------
// efe_pkg: shared types and constants of the escape frame extractor
// Command format between front and back, write port of the candidate
// buffer, configuration write bundle, channel codes and register indexes.
// ----------------------------------------------------------------------------
package efe_pkg;

    // Candidate buffer geometry
    localparam int CAPACITY   = 64;
    localparam int AW         = $clog2(CAPACITY);
    localparam int PREFIX_LEN = 6;

    // Command queue geometry
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    // Result channel codes
    localparam logic [1:0] CH_PASS  = 2'd0;
    localparam logic [1:0] CH_CMD   = 2'd1;
    localparam logic [1:0] CH_EMPTY = 2'd2;

    // Input operation codes
    localparam logic OP_DATA = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // Configuration register indexes
    localparam logic [1:0] REG_FRAME_PREFIX  = 2'd0;
    localparam logic [1:0] REG_TERMINATOR    = 2'd1;
    localparam logic [1:0] REG_TIMEOUT_TICKS = 2'd2;

    // Configuration reset values
    localparam logic [47:0] PREFIX_RST  = 48'h1B5D3737373B;
    localparam logic [7:0]  TERM_RST    = 8'h07;
    localparam logic [15:0] TIMEOUT_RST = 16'd500;

    localparam logic [15:0] IDLE_MAX = 16'hFFFF;

    // Work item for the back end: replay buffer entries rd_first..rd_end-1
    // on rd_chan, then one trailing byte when tail_valid is set.
    typedef struct packed {
        logic [AW-1:0] rd_first;
        logic [AW-1:0] rd_end;
        logic [1:0]    rd_chan;
        logic          tail_valid;
        logic [1:0]    tail_chan;
        logic [7:0]    tail_byte;
    } cmd_t;

    typedef struct packed {
        logic          en;
        logic [AW-1:0] addr;
        logic [7:0]    data;
    } mem_wr_t;

    typedef struct packed {
        logic        we;
        logic [1:0]  index;
        logic [47:0] data;
    } cfg_wr_t;

    typedef struct packed {
        logic          push;
        logic          busy;
        logic [AW-1:0] held_count;
    } front_status_t;

    typedef struct packed {
        logic pop;
        logic range_done;
    } back_status_t;

    // Expected prefix byte at position idx, first byte in the top octet
    function automatic logic [7:0] prefix_byte(input logic [47:0] prefix,
                                               input logic [2:0]  idx);
        logic [7:0] sel;
        case (idx)
            3'd0:    sel = prefix[47:40];
            3'd1:    sel = prefix[39:32];
            3'd2:    sel = prefix[31:24];
            3'd3:    sel = prefix[23:16];
            3'd4:    sel = prefix[15:8];
            3'd5:    sel = prefix[7:0];
            default: sel = 8'h00;
        endcase
        return sel;
    endfunction

endpackage

/* hw/rtl/efe_in_if.sv */
// ----------------------------------------------------------------------------
// efe_in_if: input beat channel
// Valid/ready channel carrying one operation and one data byte per beat.
// ----------------------------------------------------------------------------
interface efe_in_if;
    logic       valid;
    logic       ready;
    logic       operation;
    logic [7:0] data_byte;

    modport source (output valid, output operation, output data_byte, input ready);
    modport sink   (input valid, input operation, input data_byte, output ready);
endinterface

/* hw/rtl/efe_out_if.sv */
// ----------------------------------------------------------------------------
// efe_out_if: result beat channel
// Valid/ready channel carrying one result (channel, byte, last) per beat.
// ----------------------------------------------------------------------------
interface efe_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] channel;
    logic [7:0] out_byte;
    logic       last;

    modport source (output valid, output channel, output out_byte, output last,
                    input ready);
    modport sink   (input valid, input channel, input out_byte, input last,
                    output ready);
endinterface

/* hw/rtl/efe_front.sv */
// ----------------------------------------------------------------------------
// efe_front: input classifier
// Holds the configuration registers and the candidate count and idle timer,
// writes candidate bytes into the back end buffer and issues replay, payload
// and single-byte commands to the command queue.
// ----------------------------------------------------------------------------
module efe_front (
    input  logic                   clk,
    input  logic                   rst_n,
    efe_in_if.sink                 rx,
    input  efe_pkg::cfg_wr_t       cfg,
    input  logic                   q_full,
    input  efe_pkg::back_status_t  back_st,
    output efe_pkg::cmd_t          push_cmd,
    output efe_pkg::mem_wr_t       mem_wr,
    output efe_pkg::front_status_t status
);
    import efe_pkg::*;

    logic [47:0]   prefix_reg;
    logic [7:0]    term_reg;
    logic [15:0]   timeout_reg;
    logic [AW-1:0] cnt_reg, cnt_next;
    logic [15:0]   idle_reg, idle_next;
    logic          busy_reg, busy_next;

    logic          accept;
    logic          push;
    logic [15:0]   idle_inc;
    logic [7:0]    b;
    cmd_t          cmd;

    assign rx.ready = !busy_reg && !q_full;
    assign accept   = rx.valid && rx.ready;
    assign b        = rx.data_byte;
    assign idle_inc = (idle_reg == IDLE_MAX) ? idle_reg : idle_reg + 16'd1;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prefix_reg  <= PREFIX_RST;
            term_reg    <= TERM_RST;
            timeout_reg <= TIMEOUT_RST;
        end
        else if (cfg.we)
        begin
            case (cfg.index)
                REG_FRAME_PREFIX:  prefix_reg  <= cfg.data;
                REG_TERMINATOR:    term_reg    <= cfg.data[7:0];
                REG_TIMEOUT_TICKS: timeout_reg <= cfg.data[15:0];
                default:           ;
            endcase
        end
    end

    // Classify the accepted beat
    always_comb
    begin
        cnt_next  = cnt_reg;
        idle_next = idle_reg;
        push      = 1'b0;
        cmd       = '0;
        mem_wr    = '0;
        mem_wr.addr = cnt_reg;
        mem_wr.data = b;
        if (accept)
        begin
            if (rx.operation == OP_TICK)
            begin
                if (cnt_reg != '0)
                begin
                    if (idle_inc >= timeout_reg)
                    begin
                        // timeout: replay all held bytes
                        push         = 1'b1;
                        cmd.rd_end   = cnt_reg;
                        cmd.rd_chan  = CH_PASS;
                        cnt_next     = '0;
                        idle_next    = '0;
                    end
                    else
                    begin
                        idle_next = idle_inc;
                    end
                end
            end
            else if (cnt_reg == '0)
            begin
                if (b == prefix_byte(prefix_reg, 3'd0))
                begin
                    mem_wr.en   = 1'b1;
                    mem_wr.addr = '0;
                    cnt_next    = AW'(1);
                    idle_next   = '0;
                end
                else
                begin
                    push           = 1'b1;
                    cmd.tail_valid = 1'b1;
                    cmd.tail_chan  = CH_PASS;
                    cmd.tail_byte  = b;
                end
            end
            else
            begin
                idle_next = '0;
                if (cnt_reg < AW'(PREFIX_LEN))
                begin
                    if (b == prefix_byte(prefix_reg, cnt_reg[2:0]))
                    begin
                        mem_wr.en = 1'b1;
                        cnt_next  = cnt_reg + AW'(1);
                    end
                    else
                    begin
                        // mismatch: replay held bytes, then this one
                        push           = 1'b1;
                        cmd.rd_end     = cnt_reg;
                        cmd.rd_chan    = CH_PASS;
                        cmd.tail_valid = 1'b1;
                        cmd.tail_chan  = CH_PASS;
                        cmd.tail_byte  = b;
                        cnt_next       = '0;
                    end
                end
                else if (b == term_reg)
                begin
                    push = 1'b1;
                    if (cnt_reg == AW'(PREFIX_LEN))
                    begin
                        cmd.tail_valid = 1'b1;
                        cmd.tail_chan  = CH_EMPTY;
                        cmd.tail_byte  = 8'h00;
                    end
                    else
                    begin
                        cmd.rd_first = AW'(PREFIX_LEN);
                        cmd.rd_end   = cnt_reg;
                        cmd.rd_chan  = CH_CMD;
                    end
                    cnt_next = '0;
                end
                else if (cnt_reg >= AW'(CAPACITY - 1))
                begin
                    // buffer full: replay held bytes, then this one
                    push           = 1'b1;
                    cmd.rd_end     = cnt_reg;
                    cmd.rd_chan    = CH_PASS;
                    cmd.tail_valid = 1'b1;
                    cmd.tail_chan  = CH_PASS;
                    cmd.tail_byte  = b;
                    cnt_next       = '0;
                end
                else
                begin
                    mem_wr.en = 1'b1;
                    cnt_next  = cnt_reg + AW'(1);
                end
            end
        end
    end

    // Hold off new beats while the back end still reads the buffer
    always_comb
    begin
        busy_next = busy_reg;
        if (push && (cmd.rd_first != cmd.rd_end))
            busy_next = 1'b1;
        else if (back_st.range_done)
            busy_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            idle_reg <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            idle_reg <= idle_next;
            busy_reg <= busy_next;
        end
    end

    assign push_cmd          = cmd;
    assign status.push       = push;
    assign status.busy       = busy_reg;
    assign status.held_count = cnt_reg;

endmodule

/* hw/rtl/efe_cmd_queue.sv */
// ----------------------------------------------------------------------------
// efe_cmd_queue: command queue between front and back
// Small register FIFO of commands; push and pop may coincide.
// ----------------------------------------------------------------------------
module efe_cmd_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  efe_pkg::cmd_t push_cmd,
    input  logic          pop,
    output efe_pkg::cmd_t head,
    output logic          full,
    output logic          empty
);
    import efe_pkg::*;

    cmd_t           entry_reg [QDEPTH];
    logic [QAW-1:0] wr_ptr_reg;
    logic [QAW-1:0] rd_ptr_reg;
    logic [QAW:0]   count_reg, count_next;

    assign full  = (count_reg == (QAW+1)'(QDEPTH));
    assign empty = (count_reg == '0);
    assign head  = entry_reg[rd_ptr_reg];

    // Store pushed commands
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

    always_comb
    begin
        count_next = count_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + (QAW+1)'(1);
            2'b01:   count_next = count_reg - (QAW+1)'(1);
            default: count_next = count_reg;
        endcase
    end

    // Advance pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + QAW'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + QAW'(1);
            count_reg <= count_next;
        end
    end

endmodule

/* hw/rtl/efe_back.sv */
// ----------------------------------------------------------------------------
// efe_back: result sequencer
// Owns the candidate buffer. Walks each command one result per cycle while tx is
// ready: buffer read, read-data stage, output register.
// ----------------------------------------------------------------------------
module efe_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  efe_pkg::mem_wr_t      mem_wr,
    input  efe_pkg::cmd_t         head,
    input  logic                  q_empty,
    output efe_pkg::back_status_t status,
    efe_out_if.source             tx
);
    import efe_pkg::*;

    logic [7:0]    mem [CAPACITY];

    logic          active_reg;
    cmd_t          cmd_reg;
    logic [AW-1:0] ptr_reg;

    logic          s1_valid_reg;
    logic          s1_from_mem_reg;
    logic [1:0]    s1_chan_reg;
    logic          s1_last_reg;
    logic [7:0]    s1_byte_reg;
    logic [7:0]    rd_data_reg;

    logic          out_valid_reg;
    logic [1:0]    out_chan_reg;
    logic [7:0]    out_byte_reg;
    logic          out_last_reg;

    cmd_t          cur;
    logic [AW-1:0] ptr;
    logic [AW:0]   ptr_inc;
    logic          have, out_adv, can_issue, issue;
    logic          in_range, range_last, el_last;

    // Pick the command in work: the loaded one or the queue head
    assign cur     = active_reg ? cmd_reg : head;
    assign ptr     = active_reg ? ptr_reg : head.rd_first;
    assign ptr_inc = {1'b0, ptr} + (AW+1)'(1);

    assign have      = active_reg || !q_empty;
    assign out_adv   = !out_valid_reg || tx.ready;
    assign can_issue = !s1_valid_reg || out_adv;
    assign issue     = have && can_issue;

    assign in_range   = (ptr < cur.rd_end);
    assign range_last = in_range && (ptr_inc == {1'b0, cur.rd_end});
    assign el_last    = in_range ? (range_last && !cur.tail_valid) : 1'b1;

    assign status.pop        = issue && !active_reg;
    assign status.range_done = issue && range_last;

    // Buffer write from the front, registered read for the walk
    always_ff @(posedge clk)
    begin
        if (mem_wr.en)
            mem[mem_wr.addr] <= mem_wr.data;
        if (issue && in_range)
            rd_data_reg <= mem[ptr];
    end

    // Sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
        end
        else if (issue)
        begin
            active_reg <= !el_last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue && !active_reg)
            cmd_reg <= head;
        if (issue && in_range)
            ptr_reg <= ptr_inc[AW-1:0];
    end

    // Read-data stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (can_issue)
            s1_valid_reg <= issue;
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            s1_from_mem_reg <= in_range;
            s1_chan_reg     <= in_range ? cur.rd_chan : cur.tail_chan;
            s1_last_reg     <= el_last;
            s1_byte_reg     <= cur.tail_byte;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_adv)
            out_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (out_adv && s1_valid_reg)
        begin
            out_chan_reg <= s1_chan_reg;
            out_byte_reg <= s1_from_mem_reg ? rd_data_reg : s1_byte_reg;
            out_last_reg <= s1_last_reg;
        end
    end

    assign tx.valid    = out_valid_reg;
    assign tx.channel  = out_chan_reg;
    assign tx.out_byte = out_byte_reg;
    assign tx.last     = out_last_reg;

endmodule

/* hw/rtl/escape_frame_extractor.sv */
// ----------------------------------------------------------------------------
// escape_frame_extractor: in-band command frame extractor
// Passes a byte stream through and pulls out frames made of a six-byte
// prefix, payload bytes and a terminator byte.
//
//   port   | dir | handshake        | payload
//   -------+-----+------------------+-------------------------------------
//   rx     | in  | valid / ready    | operation, data_byte
//   tx     | out | valid / ready    | channel, out_byte, last
//   cfg_*  | in  | cfg_we only      | cfg_index, cfg_data (48 bit)
//
// A beat that makes no result or a single result does not stall rx; results
// pass the command queue, the read-data stage and the output register, one per
// cycle while tx is ready. A replay or payload keeps the back end reading its
// buffer entries one at a time (one buffer read port) and rx stalls until its
// last entry is read. rx also stalls while the four-entry command queue is full.
// Reset clears all control state; the buffer needs no clearing pass.
// ----------------------------------------------------------------------------
module escape_frame_extractor (
    input  logic        clk,
    input  logic        rst_n,
    efe_in_if.sink      rx,
    efe_out_if.source   tx,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [47:0] cfg_data
);
    import efe_pkg::*;

    cfg_wr_t       cfg;
    cmd_t          push_cmd;
    cmd_t          head;
    mem_wr_t       mem_wr;
    front_status_t front_st;
    back_status_t  back_st;
    logic          q_full;
    logic          q_empty;

    assign cfg.we    = cfg_we;
    assign cfg.index = cfg_index;
    assign cfg.data  = cfg_data;

    // Classify beats
    efe_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .rx       (rx),
        .cfg      (cfg),
        .q_full   (q_full),
        .back_st  (back_st),
        .push_cmd (push_cmd),
        .mem_wr   (mem_wr),
        .status   (front_st)
    );

    // Buffer commands
    efe_cmd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (front_st.push),
        .push_cmd (push_cmd),
        .pop      (back_st.pop),
        .head     (head),
        .full     (q_full),
        .empty    (q_empty)
    );

    // Emit results
    efe_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .mem_wr  (mem_wr),
        .head    (head),
        .q_empty (q_empty),
        .status  (back_st),
        .tx      (tx)
    );

`ifndef ASSERT_OFF
    // No buffer write while a replay or payload walk is pending
    a_no_write_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        mem_wr.en |-> !front_st.busy)
        else $error("buffer written during a pending walk");

    // A walk can only finish while the front is held off
    a_done_only_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        back_st.range_done |-> front_st.busy)
        else $error("walk finished with no walk pending");

    // Never push into a full queue, never pop an empty one
    a_queue_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        !(front_st.push && q_full) && !(back_st.pop && q_empty))
        else $error("command queue overflow or underflow");

    // An empty-frame marker is always the only result of its beat
    a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (tx.valid && tx.channel == CH_EMPTY) |-> (tx.last && tx.out_byte == 8'h00))
        else $error("empty-frame marker malformed");
`endif

endmodule
